// ===== hw/rtl/scma_pkg.sv =====
`default_nettype none
package scma_pkg;

    localparam int unsigned NUM_CLASSES  = 11;
    localparam int unsigned SLAB_BYTES   = 2 * 1024 * 1024;
    localparam int unsigned MAG_DEPTH    = 32;
    localparam int unsigned MAX_SLABS    = 8;
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned MIN_USER     = 64;

    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned SIZE_W  = 24;
    localparam int unsigned STAT_W  = 32;
    localparam int unsigned BYTES_W = 25;
    localparam int unsigned LIMIT_W = 4;
    localparam int unsigned LIMIT_RESET = 8;

    localparam int unsigned PER_SLAB   = SLAB_BYTES / (HEADER_BYTES + MIN_USER);
    localparam int unsigned LINK_DEPTH = MAX_SLABS * PER_SLAB;
    localparam int unsigned NODE_W     = $clog2(LINK_DEPTH + 1);
    localparam int unsigned IDX_W      = $clog2(LINK_DEPTH);
    localparam int unsigned SLAB_AW    = $clog2(SLAB_BYTES);
    localparam int unsigned K_W        = $clog2(MAX_SLABS);
    localparam int unsigned SU_W       = $clog2(MAX_SLABS + 1);
    localparam int unsigned CNT_W      = $clog2(PER_SLAB + 1);
    localparam int unsigned CLS_W      = $clog2(NUM_CLASSES + 1);
    localparam int unsigned FILL_W     = $clog2(MAG_DEPTH + 1);
    localparam int unsigned HDR_SH     = $clog2(HEADER_BYTES);
    localparam int unsigned MIN_SH     = $clog2(MIN_USER);
    localparam int unsigned DIV_W      = SLAB_AW - HDR_SH;
    localparam int unsigned MAX_USER   = MIN_USER << (NUM_CLASSES - 1);
    localparam int unsigned D_MAX      = (HEADER_BYTES + MAX_USER) / HEADER_BYTES;
    localparam int unsigned D_W        = $clog2(D_MAX + 1);

    localparam logic [CNT_W-1:0] BLOCKS_PER_SLAB [NUM_CLASSES] = '{
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 0))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 1))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 2))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 3))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 4))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 5))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 6))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 7))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 8))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 9))),
        CNT_W'(SLAB_BYTES / (HEADER_BYTES + (MIN_USER << 10)))
    };

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_ZERO = 3'd1,
        ST_BIG  = 3'd2,
        ST_OOM  = 3'd3,
        ST_BAD  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLASS,
        OP_STATUS,
        OP_PROBE,
        OP_HEAD_RD,
        OP_POP,
        OP_ADDR1,
        OP_ADDR2,
        OP_REFILL_CHK,
        OP_REFILL_MV,
        OP_CARVE_INIT,
        OP_CARVE_STEP,
        OP_TRY,
        OP_FREE_CHK,
        OP_DIV_STEP,
        OP_FREE_OK,
        OP_FLUSH_CHK,
        OP_FLUSH_MV,
        OP_FLUSH_END,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic req_free;
        logic size_zero;
        logic size_big;
        logic mag_nz;
        logic refill_go;
        logic carve_ok;
        logic carve_last;
        logic try_done;
        logic faddr_ok;
        logic div_last;
        logic free_ok;
        logic mag_room;
        logic flush_go;
        logic out_room;
    } t_sts;

    function automatic logic [NODE_W-1:0] slab_base(input logic [K_W-1:0] k);
        return NODE_W'(k) * NODE_W'(PER_SLAB);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scma_req_if.sv =====
`default_nettype none
interface scma_req_if import scma_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output req_type, output req_size, output free_address,
                    input ready);
    modport sink (input valid, input req_type, input req_size, input free_address,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/scma_rsp_if.sv =====
`default_nettype none
interface scma_rsp_if import scma_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [ADDR_W-1:0]  address;
    logic [STAT_W-1:0]  alloc_count;
    logic [STAT_W-1:0]  free_count;
    logic [STAT_W-1:0]  hit_count;
    logic [STAT_W-1:0]  miss_count;
    logic [BYTES_W-1:0] live_bytes;
    logic [BYTES_W-1:0] mapped_bytes;

    modport source (output valid, output status, output address, output alloc_count,
                    output free_count, output hit_count, output miss_count,
                    output live_bytes, output mapped_bytes, input ready);
    modport sink (input valid, input status, input address, input alloc_count,
                  input free_count, input hit_count, input miss_count,
                  input live_bytes, input mapped_bytes, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/size_class_magazine_allocator.sv =====
// Alloc: a hit pops the magazine; on a miss a refill moves blocks from the depot into the magazine,
// and if none are left a new slab is carved, one block at a time (up to PER_SLAB per slab).
// Free: the address is checked by the 18-step remainder divider; a flush moves blocks to the depot.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset (synchronous): lists emptied, counters cleared, slab_limit back to 8; the link
// memory is not cleared.
`default_nettype none
module size_class_magazine_allocator import scma_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    scma_req_if.sink                i_req,
    scma_rsp_if.source              o_rsp
);
    t_cmd    cmd;
    t_sts    sts;
    t_status rsp_status;

    scma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    scma_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req.req_type),
        .i_req_size     (i_req.req_size),
        .i_free_address (i_req.free_address),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_status       (rsp_status),
        .o_address      (o_rsp.address),
        .o_alloc_count  (o_rsp.alloc_count),
        .o_free_count   (o_rsp.free_count),
        .o_hit_count    (o_rsp.hit_count),
        .o_miss_count   (o_rsp.miss_count),
        .o_live_bytes   (o_rsp.live_bytes),
        .o_mapped_bytes (o_rsp.mapped_bytes)
    );

    assign o_rsp.status = rsp_status;
endmodule
`default_nettype wire

// ===== hw/rtl/scma_ram.sv =====
`default_nettype none
module scma_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/scma_dp.sv =====
`default_nettype none
module scma_dp import scma_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    input  wire logic               i_req_type,
    input  wire logic [SIZE_W-1:0]  i_req_size,
    input  wire logic [ADDR_W-1:0]  i_free_address,
    input  wire logic               i_rsp_ready,
    output logic                    o_rsp_valid,
    output t_status                 o_status,
    output logic [ADDR_W-1:0]       o_address,
    output logic [STAT_W-1:0]       o_alloc_count,
    output logic [STAT_W-1:0]       o_free_count,
    output logic [STAT_W-1:0]       o_hit_count,
    output logic [STAT_W-1:0]       o_miss_count,
    output logic [BYTES_W-1:0]      o_live_bytes,
    output logic [BYTES_W-1:0]      o_mapped_bytes
);
    logic               r_type;
    logic [SIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]  r_faddr;
    logic [CLS_W-1:0]   r_cls;
    t_status            r_status;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_try;
    logic [NODE_W-1:0]  r_node;
    logic [K_W-1:0]     r_k;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_cnt;
    logic [D_W-1:0]     r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [NODE_W-1:0]  r_mag_head [NUM_CLASSES];
    logic [FILL_W-1:0]  r_mag_fill [NUM_CLASSES];
    logic [NODE_W-1:0]  r_depot_head [NUM_CLASSES];
    logic [CLS_W-1:0]   r_slab_class [MAX_SLABS];
    logic [SU_W-1:0]    r_slabs_used;
    logic [LIMIT_W-1:0] r_limit;
    logic [STAT_W-1:0]  r_alloc;
    logic [STAT_W-1:0]  r_free;
    logic [STAT_W-1:0]  r_hit;
    logic [STAT_W-1:0]  r_miss;
    logic [BYTES_W-1:0] r_live;
    logic [BYTES_W-1:0] r_mapped;
    logic               r_ovalid;

    logic [NODE_W-1:0]  cur_head;
    logic [FILL_W-1:0]  cur_fill;
    logic [NODE_W-1:0]  cur_depot;
    logic [SU_W-1:0]    lim;
    logic [ADDR_W-1:0]  f_s;
    logic [K_W-1:0]     f_k;
    logic [K_W-1:0]     sc_idx;
    logic [CLS_W-1:0]   sc_val;
    logic [NODE_W-1:0]  f_node;
    logic [IDX_W-1:0]   a_n;
    logic [K_W-1:0]     a_k;
    logic [CNT_W-1:0]   a_i;
    logic [31:0]        a_off;
    logic [ADDR_W-1:0]  a_addr;
    logic [D_W-1:0]     div_d;
    logic [D_W:0]       div_t;
    logic               div_ge;
    logic [D_W:0]       div_sub;
    logic [BYTES_W-1:0] cls_bytes;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [NODE_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [NODE_W-1:0]  ram_rdata;

    function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NUM_CLASSES - 1);
        for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
            if (BYTES_W'(size) <= (BYTES_W'(MIN_USER) << j)) begin
                c = CLS_W'(j);
            end
        end
        return c;
    endfunction

    function automatic logic [K_W-1:0] slab_of(input logic [IDX_W-1:0] n);
        logic [K_W-1:0] k;
        k = '0;
        for (int j = 1; j < MAX_SLABS; j++) begin
            if (n >= IDX_W'(j * PER_SLAB)) begin
                k = K_W'(j);
            end
        end
        return k;
    endfunction

    function automatic logic [IDX_W-1:0] link_idx(input logic [NODE_W-1:0] node);
        return IDX_W'(node - NODE_W'(1));
    endfunction

    assign cur_head  = r_mag_head[r_cls];
    assign cur_fill  = r_mag_fill[r_cls];
    assign cur_depot = r_depot_head[r_cls];
    assign lim       = (r_limit < LIMIT_W'(MAX_SLABS)) ? SU_W'(r_limit) : SU_W'(MAX_SLABS);

    assign f_s    = r_faddr - ADDR_W'(HEADER_BYTES);
    assign f_k    = f_s[ADDR_W-1:SLAB_AW];
    assign sc_idx = r_type ? f_k : r_k;
    assign sc_val = r_slab_class[sc_idx];
    assign f_node = slab_base(r_k) + NODE_W'(r_quo[CNT_W-1:0]) + NODE_W'(1);

    assign a_n    = link_idx(r_node);
    assign a_k    = slab_of(a_n);
    assign a_i    = CNT_W'(a_n - IDX_W'(slab_base(a_k)));
    assign a_off  = (32'(r_i) << HDR_SH) + ((32'(r_i) << MIN_SH) << sc_val);
    assign a_addr = (ADDR_W'(r_k) << SLAB_AW) + a_off[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);

    assign div_d   = D_W'(1) + (D_W'(MIN_USER / HEADER_BYTES) << r_cls);
    assign div_t   = {r_rem, r_quo[DIV_W-1]};
    assign div_ge  = div_t >= {1'b0, div_d};
    assign div_sub = div_ge ? (div_t - {1'b0, div_d}) : div_t;

    assign cls_bytes = BYTES_W'(MIN_USER) << r_cls;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = link_idx(r_node);
        ram_wdata = cur_depot;
        case (i_cmd.op)
            OP_REFILL_MV: begin
                ram_we    = 1'b1;
                ram_waddr = link_idx(cur_depot);
                ram_wdata = cur_head;
            end
            OP_CARVE_STEP, OP_FLUSH_END: begin
                ram_we = 1'b1;
            end
            OP_FREE_OK: begin
                ram_we    = cur_fill < FILL_W'(MAG_DEPTH);
                ram_waddr = link_idx(f_node);
                ram_wdata = cur_head;
            end
            OP_FLUSH_MV: begin
                ram_we    = 1'b1;
                ram_waddr = link_idx(cur_head);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = (i_cmd.op == OP_REFILL_CHK) ? link_idx(cur_depot) : link_idx(cur_head);

    scma_ram #(
        .WIDTH (NODE_W),
        .DEPTH (LINK_DEPTH)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.req_free   = r_type;
        o_sts.size_zero  = r_size == '0;
        o_sts.size_big   = BYTES_W'(r_size) > BYTES_W'(MAX_USER);
        o_sts.mag_nz     = cur_head != '0;
        o_sts.refill_go  = (cur_fill < FILL_W'(MAG_DEPTH)) && (cur_depot != '0);
        o_sts.carve_ok   = r_slabs_used < lim;
        o_sts.carve_last = r_cnt == CNT_W'(1);
        o_sts.try_done   = r_try;
        o_sts.faddr_ok   = (r_faddr >= ADDR_W'(HEADER_BYTES)) && (SU_W'(f_k) < r_slabs_used)
                           && (f_s[HDR_SH-1:0] == '0) && (sc_val < CLS_W'(NUM_CLASSES));
        o_sts.div_last   = r_cnt == CNT_W'(1);
        o_sts.free_ok    = (r_rem == '0) && (r_quo < DIV_W'(BLOCKS_PER_SLAB[r_cls]));
        o_sts.mag_room   = cur_fill < FILL_W'(MAG_DEPTH);
        o_sts.flush_go   = (cur_fill > FILL_W'(MAG_DEPTH / 2)) && (cur_head != '0);
        o_sts.out_room   = !r_ovalid || i_rsp_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_CLASSES; j++) begin
                r_mag_head[j]   <= '0;
                r_mag_fill[j]   <= '0;
                r_depot_head[j] <= '0;
            end
            r_slabs_used <= '0;
            r_limit      <= LIMIT_W'(LIMIT_RESET);
            r_alloc      <= '0;
            r_free       <= '0;
            r_hit        <= '0;
            r_miss       <= '0;
            r_live       <= '0;
            r_mapped     <= '0;
            r_ovalid     <= 1'b0;
            r_try        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLASS: begin
                    r_try <= 1'b0;
                end
                OP_TRY: begin
                    r_try <= 1'b1;
                end
                OP_PROBE: begin
                    if (cur_head == '0) begin
                        r_miss <= r_miss + STAT_W'(1);
                    end
                end
                OP_POP: begin
                    r_mag_head[r_cls] <= ram_rdata;
                    r_mag_fill[r_cls] <= cur_fill - FILL_W'(1);
                    r_hit             <= r_hit + STAT_W'(1);
                end
                OP_ADDR2: begin
                    r_alloc <= r_alloc + STAT_W'(1);
                    r_live  <= r_live + cls_bytes;
                end
                OP_REFILL_MV: begin
                    r_depot_head[r_cls] <= ram_rdata;
                    r_mag_head[r_cls]   <= cur_depot;
                    r_mag_fill[r_cls]   <= cur_fill + FILL_W'(1);
                end
                OP_CARVE_INIT: begin
                    r_slabs_used <= r_slabs_used + SU_W'(1);
                    r_mapped     <= r_mapped + BYTES_W'(SLAB_BYTES);
                end
                OP_CARVE_STEP: begin
                    r_depot_head[r_cls] <= r_node;
                end
                OP_FREE_OK: begin
                    r_live <= r_live - cls_bytes;
                    r_free <= r_free + STAT_W'(1);
                    if (cur_fill < FILL_W'(MAG_DEPTH)) begin
                        r_mag_head[r_cls] <= f_node;
                        r_mag_fill[r_cls] <= cur_fill + FILL_W'(1);
                        r_hit             <= r_hit + STAT_W'(1);
                    end
                end
                OP_FLUSH_MV: begin
                    r_mag_head[r_cls]   <= ram_rdata;
                    r_mag_fill[r_cls]   <= cur_fill - FILL_W'(1);
                    r_depot_head[r_cls] <= cur_head;
                end
                OP_FLUSH_END: begin
                    r_depot_head[r_cls] <= r_node;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_type   <= i_req_type;
                r_size   <= i_req_size;
                r_faddr  <= i_free_address;
                r_status <= ST_OK;
                r_addr   <= '0;
            end
            OP_CLASS: begin
                r_cls <= size_class(r_size);
            end
            OP_STATUS: begin
                r_status <= i_cmd.status;
            end
            OP_POP: begin
                r_node <= cur_head;
            end
            OP_ADDR1: begin
                r_k <= a_k;
                r_i <= a_i;
            end
            OP_ADDR2: begin
                r_addr <= a_addr;
            end
            OP_CARVE_INIT: begin
                r_slab_class[r_slabs_used[K_W-1:0]] <= r_cls;
                r_node <= slab_base(r_slabs_used[K_W-1:0]) + NODE_W'(1);
                r_cnt  <= BLOCKS_PER_SLAB[r_cls];
            end
            OP_CARVE_STEP: begin
                r_node <= r_node + NODE_W'(1);
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            OP_FREE_CHK: begin
                r_k   <= f_k;
                r_cls <= sc_val;
                r_rem <= '0;
                r_quo <= f_s[SLAB_AW-1:HDR_SH];
                r_cnt <= CNT_W'(DIV_W);
            end
            OP_DIV_STEP: begin
                r_rem <= div_sub[D_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_FREE_OK: begin
                r_node <= f_node;
            end
            OP_EMIT: begin
                o_status       <= r_status;
                o_address      <= r_addr;
                o_alloc_count  <= r_alloc;
                o_free_count   <= r_free;
                o_hit_count    <= r_hit;
                o_miss_count   <= r_miss;
                o_live_bytes   <= r_live;
                o_mapped_bytes <= r_mapped;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp_valid = r_ovalid;
endmodule
`default_nettype wire

// ===== hw/rtl/scma_ctrl.sv =====
`default_nettype none
module scma_ctrl import scma_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire t_sts i_sts,
    output logic      o_req_ready,
    output t_cmd      o_cmd
);
    typedef enum logic [18:0] {
        S_IDLE   = 19'b0000000000000000001,
        S_DECODE = 19'b0000000000000000010,
        S_PROBE  = 19'b0000000000000000100,
        S_POP    = 19'b0000000000000001000,
        S_ADDR1  = 19'b0000000000000010000,
        S_ADDR2  = 19'b0000000000000100000,
        S_RCHK   = 19'b0000000000001000000,
        S_RMOV   = 19'b0000000000010000000,
        S_REND   = 19'b0000000000100000000,
        S_CINIT  = 19'b0000000001000000000,
        S_CSTEP  = 19'b0000000010000000000,
        S_CEND   = 19'b0000000100000000000,
        S_FCHK   = 19'b0000001000000000000,
        S_FDIV   = 19'b0000010000000000000,
        S_FVAL   = 19'b0000100000000000000,
        S_FLCHK  = 19'b0001000000000000000,
        S_FLMOV  = 19'b0010000000000000000,
        S_FLEND  = 19'b0100000000000000000,
        S_EMIT   = 19'b1000000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.req_free) begin
                    n_state = S_FCHK;
                end else if (i_sts.size_zero) begin
                    o_cmd.op     = OP_STATUS;
                    o_cmd.status = ST_ZERO;
                    n_state      = S_EMIT;
                end else if (i_sts.size_big) begin
                    o_cmd.op     = OP_STATUS;
                    o_cmd.status = ST_BIG;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.op = OP_CLASS;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.op = OP_PROBE;
                n_state  = i_sts.mag_nz ? S_POP : S_RCHK;
            end
            S_POP: begin
                o_cmd.op = OP_POP;
                n_state  = S_ADDR1;
            end
            S_ADDR1: begin
                o_cmd.op = OP_ADDR1;
                n_state  = S_ADDR2;
            end
            S_ADDR2: begin
                o_cmd.op = OP_ADDR2;
                n_state  = S_EMIT;
            end
            S_RCHK: begin
                o_cmd.op = OP_REFILL_CHK;
                n_state  = i_sts.refill_go ? S_RMOV : S_REND;
            end
            S_RMOV: begin
                o_cmd.op = OP_REFILL_MV;
                n_state  = S_RCHK;
            end
            S_REND: begin
                if (i_sts.mag_nz) begin
                    o_cmd.op = OP_HEAD_RD;
                    n_state  = S_POP;
                end else if (i_sts.carve_ok) begin
                    n_state = S_CINIT;
                end else begin
                    o_cmd.op     = OP_STATUS;
                    o_cmd.status = ST_OOM;
                    n_state      = S_EMIT;
                end
            end
            S_CINIT: begin
                o_cmd.op = OP_CARVE_INIT;
                n_state  = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.op = OP_CARVE_STEP;
                if (i_sts.carve_last) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                if (i_sts.try_done) begin
                    o_cmd.op     = OP_STATUS;
                    o_cmd.status = ST_OOM;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.op = OP_TRY;
                    n_state  = S_PROBE;
                end
            end
            S_FCHK: begin
                if (i_sts.faddr_ok) begin
                    o_cmd.op = OP_FREE_CHK;
                    n_state  = S_FDIV;
                end else begin
                    o_cmd.op     = OP_STATUS;
                    o_cmd.status = ST_BAD;
                    n_state      = S_EMIT;
                end
            end
            S_FDIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_FVAL;
                end
            end
            S_FVAL: begin
                if (i_sts.free_ok) begin
                    o_cmd.op = OP_FREE_OK;
                    n_state  = i_sts.mag_room ? S_EMIT : S_FLCHK;
                end else begin
                    o_cmd.op     = OP_STATUS;
                    o_cmd.status = ST_BAD;
                    n_state      = S_EMIT;
                end
            end
            S_FLCHK: begin
                o_cmd.op = OP_FLUSH_CHK;
                n_state  = i_sts.flush_go ? S_FLMOV : S_FLEND;
            end
            S_FLMOV: begin
                o_cmd.op = OP_FLUSH_MV;
                n_state  = S_FLCHK;
            end
            S_FLEND: begin
                o_cmd.op = OP_FLUSH_END;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_room) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = r_state == S_IDLE;
endmodule
`default_nettype wire

// ===== dv/size_class_magazine_allocator_tb.sv =====
`timescale 1ns / 100ps
module size_class_magazine_allocator_tb;
    import scma_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct {
        logic              is_free;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                from_live;
    } request_t;

    typedef struct {
        t_status            status;
        logic [ADDR_W-1:0]  address;
        logic [STAT_W-1:0]  allocs;
        logic [STAT_W-1:0]  frees;
        logic [STAT_W-1:0]  hits;
        logic [STAT_W-1:0]  misses;
        logic [BYTES_W-1:0] live;
        logic [BYTES_W-1:0] mapped;
    } reply_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_data;

    scma_req_if req_ch ();
    scma_rsp_if rsp_ch ();

    size_class_magazine_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    request_t          pending_requests[$];
    reply_t            pending_replies[$];
    logic [ADDR_W-1:0] live_blocks[$];
    logic [ADDR_W-1:0] last_freed;
    request_t          in_flight;
    int                errors;
    int                idle_mode;
    int                hold_left;
    logic              hold_go;
    int unsigned       cycles;

    // allocator state mirror
    int unsigned        link_mem[LINK_DEPTH];
    int unsigned        mag_top[NUM_CLASSES];
    int unsigned        mag_cnt[NUM_CLASSES];
    int unsigned        depot_top[NUM_CLASSES];
    int unsigned        slab_cls[MAX_SLABS];
    int unsigned        slabs_carved;
    int unsigned        slab_cap;
    logic [STAT_W-1:0]  n_alloc, n_free, n_hit, n_miss;
    logic [BYTES_W-1:0] n_live, n_mapped;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned next_of(int unsigned node);
        return (node != 0) ? link_mem[node-1] : 0;
    endfunction

    function automatic void link_to(int unsigned node, int unsigned v);
        if (node != 0) link_mem[node-1] = v;
    endfunction

    function automatic int unsigned block_size(int unsigned c);
        return HEADER_BYTES + (MIN_USER << c);
    endfunction

    function automatic bit carve_slab(int unsigned c);
        int unsigned lim;
        int unsigned k;
        int unsigned cnt;
        lim = (slab_cap < MAX_SLABS) ? slab_cap : MAX_SLABS;
        if (slabs_carved >= lim) return 0;
        k = slabs_carved;
        slabs_carved++;
        slab_cls[k] = c;
        n_mapped = n_mapped + BYTES_W'(SLAB_BYTES);
        cnt = SLAB_BYTES / block_size(c);
        for (int unsigned i = 0; i < cnt; i++) begin
            link_to(k * PER_SLAB + i + 1, depot_top[c]);
            depot_top[c] = k * PER_SLAB + i + 1;
        end
        return 1;
    endfunction

    function automatic int unsigned pop_magazine(int unsigned c);
        int unsigned b;
        b = mag_top[c];
        mag_top[c] = next_of(b);
        mag_cnt[c]--;
        n_hit++;
        return b;
    endfunction

    function automatic int unsigned grab_block(int unsigned c);
        int unsigned b;
        for (int t = 0; t < 2; t++) begin
            if (mag_top[c] != 0) return pop_magazine(c);
            n_miss++;
            while (mag_cnt[c] < MAG_DEPTH && depot_top[c] != 0) begin
                b = depot_top[c];
                depot_top[c] = next_of(b);
                link_to(b, mag_top[c]);
                mag_top[c] = b;
                mag_cnt[c]++;
            end
            if (mag_top[c] != 0) return pop_magazine(c);
            if (!carve_slab(c)) return 0;
        end
        return 0;
    endfunction

    function automatic reply_t allocate_or_free(request_t rq);
        reply_t      r;
        int unsigned c, b, n, k, i, s, off, bb, node;
        r.status  = ST_OK;
        r.address = '0;
        if (!rq.is_free) begin
            c = 0;
            while (c < NUM_CLASSES && rq.size > (MIN_USER << c)) c++;
            if (rq.size == 0) begin
                r.status = ST_ZERO;
            end else if (c >= NUM_CLASSES) begin
                r.status = ST_BIG;
            end else begin
                b = grab_block(c);
                if (b == 0) begin
                    r.status = ST_OOM;
                end else begin
                    n = b - 1;
                    k = n / PER_SLAB;
                    i = n % PER_SLAB;
                    r.address = ADDR_W'(k * SLAB_BYTES + i * block_size(slab_cls[k])
                                        + HEADER_BYTES);
                    n_alloc++;
                    n_live = n_live + BYTES_W'(MIN_USER << c);
                    live_blocks.push_back(r.address);
                end
            end
        end else begin
            r.status = ST_BAD;
            if (rq.addr >= HEADER_BYTES) begin
                s = rq.addr - HEADER_BYTES;
                k = s / SLAB_BYTES;
                if (k < slabs_carved) begin
                    c = slab_cls[k];
                    bb = block_size(c);
                    off = s - k * SLAB_BYTES;
                    i = off / bb;
                    if (off % bb == 0 && i < SLAB_BYTES / bb) begin
                        node = k * PER_SLAB + i + 1;
                        r.status = ST_OK;
                        last_freed = rq.addr;
                        n_live = n_live - BYTES_W'(MIN_USER << c);
                        n_free++;
                        if (mag_cnt[c] < MAG_DEPTH) begin
                            link_to(node, mag_top[c]);
                            mag_top[c] = node;
                            mag_cnt[c]++;
                            n_hit++;
                        end else begin
                            while (mag_cnt[c] > MAG_DEPTH / 2 && mag_top[c] != 0) begin
                                b = mag_top[c];
                                mag_top[c] = next_of(b);
                                mag_cnt[c]--;
                                link_to(b, depot_top[c]);
                                depot_top[c] = b;
                            end
                            link_to(node, depot_top[c]);
                            depot_top[c] = node;
                        end
                    end
                end
            end
        end
        r.allocs = n_alloc;
        r.frees  = n_free;
        r.hits   = n_hit;
        r.misses = n_miss;
        r.live   = n_live;
        r.mapped = n_mapped;
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 16;
            1: return $urandom_range(99) < 68;
            default: return 0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 68;
            1: return $urandom_range(99) < 16;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        request_t rq;
        int       idx;
        if (!i_rst_n) begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= 1'b0;
            req_ch.req_size     <= '0;
            req_ch.free_address <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                pending_replies.push_back(allocate_or_free(in_flight));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_requests.size() > 0 && !sender_idles()) begin
                    rq = pending_requests.pop_front();
                    if (rq.from_live && live_blocks.size() > 0) begin
                        idx = $urandom_range(live_blocks.size() - 1);
                        rq.addr = live_blocks[idx];
                        live_blocks.delete(idx);
                    end
                    in_flight           <= rq;
                    req_ch.valid        <= 1'b1;
                    req_ch.req_type     <= rq.is_free;
                    req_ch.req_size     <= rq.size;
                    req_ch.free_address <= rq.addr;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        reply_t e;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_replies.size() == 0) begin
                    $error("reply with no request outstanding");
                    errors++;
                end else begin
                    e = pending_replies.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.address !== e.address) begin
                        $error("address: expected %0h, got %0h", e.address, rsp_ch.address);
                        errors++;
                    end
                    if (rsp_ch.alloc_count !== e.allocs) begin
                        $error("alloc_count: expected %0d, got %0d", e.allocs,
                               rsp_ch.alloc_count);
                        errors++;
                    end
                    if (rsp_ch.free_count !== e.frees) begin
                        $error("free_count: expected %0d, got %0d", e.frees, rsp_ch.free_count);
                        errors++;
                    end
                    if (rsp_ch.hit_count !== e.hits) begin
                        $error("hit_count: expected %0d, got %0d", e.hits, rsp_ch.hit_count);
                        errors++;
                    end
                    if (rsp_ch.miss_count !== e.misses) begin
                        $error("miss_count: expected %0d, got %0d", e.misses, rsp_ch.miss_count);
                        errors++;
                    end
                    if (rsp_ch.live_bytes !== e.live) begin
                        $error("live_bytes: expected %0d, got %0d", e.live, rsp_ch.live_bytes);
                        errors++;
                    end
                    if (rsp_ch.mapped_bytes !== e.mapped) begin
                        $error("mapped_bytes: expected %0d, got %0d", e.mapped,
                               rsp_ch.mapped_bytes);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= (hold_left == 0) && !receiver_idles();
        end
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= 400;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("size_class_magazine_allocator_tb: done, errors");
            $finish;
        end
    end

    task automatic push_alloc(input logic [SIZE_W-1:0] sz);
        request_t rq;
        rq.is_free   = 1'b0;
        rq.size      = sz;
        rq.addr      = ADDR_W'($urandom());
        rq.from_live = 0;
        pending_requests.push_back(rq);
    endtask

    task automatic push_free(input logic [ADDR_W-1:0] a, input bit live);
        request_t rq;
        rq.is_free   = 1'b1;
        rq.size      = SIZE_W'($urandom());
        rq.addr      = a;
        rq.from_live = live;
        pending_requests.push_back(rq);
    endtask

    task automatic push_random(input int count);
        int unsigned c, roll;
        for (int j = 0; j < count; j++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                c = $urandom_range(NUM_CLASSES - 1);
                roll = $urandom_range(99);
                if (roll < 4) push_alloc('0);
                else if (roll < 8) push_alloc($urandom_range(SIZE_W'(-1), MAX_USER + 1));
                else if (roll < 12) push_alloc(SIZE_W'($urandom()));
                else if (c == 0) push_alloc($urandom_range(MIN_USER, 1));
                else push_alloc($urandom_range(MIN_USER << c, (MIN_USER << (c - 1)) + 1));
            end else begin
                roll = $urandom_range(99);
                if (roll < 70) push_free('0, 1);
                else if (roll < 80) push_free(ADDR_W'($urandom()), 0);
                else if (roll < 88) push_free(last_freed, 0);
                else if (roll < 94) push_free(last_freed + ADDR_W'($urandom_range(1, 7)), 0);
                else push_free(ADDR_W'($urandom_range(HEADER_BYTES)), 0);
            end
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || pending_replies.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        errors       = 0;
        idle_mode    = 2;
        last_freed   = HEADER_BYTES;
        slabs_carved = 0;
        slab_cap     = LIMIT_RESET;
        n_alloc = '0; n_free = '0; n_hit = '0; n_miss = '0; n_live = '0; n_mapped = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            mag_top[c] = 0; mag_cnt[c] = 0; depot_top[c] = 0;
        end
        cycles     = 0;
        hold_left  = 0;
        hold_go    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no slabs allowed: every allocate of a legal size runs out of memory
        idle_mode = 0;
        write_limit(0);
        slab_cap = 0;
        push_alloc('0);
        push_alloc(SIZE_W'(-1));
        push_alloc(MAX_USER);
        push_alloc(MAX_USER + 1);
        push_free('0, 0);
        push_free(HEADER_BYTES - 1, 0);
        push_free(HEADER_BYTES, 0);
        push_free(ADDR_W'(-1), 0);
        push_random(40);
        drain();

        idle_mode = 1;
        write_limit(1);
        slab_cap = 1;
        push_alloc(1);
        push_alloc(MIN_USER);
        push_alloc(MIN_USER + 1);
        push_free(HEADER_BYTES + 1, 0);
        push_free(PER_SLAB * block_size(0) + HEADER_BYTES, 0);
        push_free(HEADER_BYTES, 0);
        push_free('0, 1);
        for (int j = 0; j < 36; j++) push_alloc(MIN_USER);
        for (int j = 0; j < 38; j++) push_free('0, 1);
        push_random(100);
        drain();

        idle_mode = 2;
        write_limit(15);
        slab_cap = 15;
        push_alloc(MAX_USER);
        push_random(200);
        drain();

        idle_mode = 0;
        write_limit(8);
        slab_cap = 8;
        push_random(250);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        drain();
        idle_mode = 2;
        push_random(30);
        drain();

        if (errors == 0) begin
            $display("size_class_magazine_allocator_tb: done, clean");
        end else begin
            $display("size_class_magazine_allocator_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== size_class_magazine_allocator.f =====
hw/rtl/scma_pkg.sv
hw/rtl/scma_req_if.sv
hw/rtl/scma_rsp_if.sv
hw/rtl/scma_ram.sv
hw/rtl/scma_dp.sv
hw/rtl/scma_ctrl.sv
hw/rtl/size_class_magazine_allocator.sv
dv/size_class_magazine_allocator_tb.sv
